[hdl/kts_pkg.sv]
package kts_pkg;

	// Widths of position counters.
	localparam int unsigned OFFSET_BITS = 20;
	localparam int unsigned LINE_BITS   = 16;

	// A pending word keeps its first seven bytes, byte i at bits 8i.
	localparam int unsigned PREFIX_BYTES = 7;
	localparam int unsigned PREFIX_BITS  = 8 * PREFIX_BYTES;

	localparam int unsigned KIND_BITS = 5;

	// Token kinds.
	localparam logic [KIND_BITS-1:0] KIND_EOF        = 5'd0;
	localparam logic [KIND_BITS-1:0] KIND_IDENT      = 5'd1;
	localparam logic [KIND_BITS-1:0] KIND_INTEGER    = 5'd2;
	localparam logic [KIND_BITS-1:0] KIND_STRING     = 5'd3;
	localparam logic [KIND_BITS-1:0] KIND_COLON      = 5'd4;
	localparam logic [KIND_BITS-1:0] KIND_UNTERM     = 5'd5;
	localparam logic [KIND_BITS-1:0] KIND_UNEXPECTED = 5'd6;
	localparam logic [KIND_BITS-1:0] KIND_KW_FIRST   = 5'd7;

	// Character codes the scanner treats specially.
	localparam logic [7:0] CHAR_NUL     = 8'd0;
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_SPACE   = 8'd32;
	localparam logic [7:0] CHAR_QUOTE   = 8'd34;
	localparam logic [7:0] CHAR_COLON   = 8'd58;
	localparam logic [7:0] CHAR_UNDER   = 8'd95;

	// Keyword table: literal text (right aligned) and its length.
	localparam int unsigned KW_COUNT = 12;
	localparam logic [PREFIX_BITS-1:0] KW_TEXT [KW_COUNT] = '{
		"Process", "called", "returns", "Integer", "Return", "End",
		"Let", "be", "Set", "to", "plus", "minus"
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd7, 3'd6, 3'd7, 3'd7, 3'd6, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd4, 3'd5
	};

	// Queue between the scanning front and the emitting back.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [KIND_BITS-1:0]   kind;
		logic                   is_word;
		logic [LINE_BITS-1:0]   line;
		logic [LINE_BITS-1:0]   column;
		logic [OFFSET_BITS-1:0] start;
		logic [OFFSET_BITS-1:0] length;
	} tok_t;

	// One queue entry holds every token that one request produced.
	typedef struct packed {
		logic                   two;
		tok_t                   a;
		logic [PREFIX_BITS-1:0] prefix;
		tok_t                   b;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [LINE_BITS-1:0] sat_inc_line(input logic [LINE_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [OFFSET_BITS-1:0] sat_inc_off(input logic [OFFSET_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic tok_t make_tok(
		input logic [KIND_BITS-1:0]   kind,
		input logic                   is_word,
		input logic [LINE_BITS-1:0]   line,
		input logic [LINE_BITS-1:0]   column,
		input logic [OFFSET_BITS-1:0] start,
		input logic [OFFSET_BITS-1:0] length
	);
		tok_t t;
		t.kind    = kind;
		t.is_word = is_word;
		t.line    = line;
		t.column  = column;
		t.start   = start;
		t.length  = length;
		return t;
	endfunction

	// Keyword text rearranged so that its first byte sits at the bottom.
	function automatic logic [PREFIX_BITS-1:0] kw_packed(input int unsigned idx);
		logic [PREFIX_BITS-1:0] lit;
		logic [PREFIX_BITS-1:0] res;
		int unsigned n;
		lit = KW_TEXT[idx];
		n   = KW_LEN[idx];
		res = '0;
		for (int unsigned j = 0; j < PREFIX_BYTES; j++) begin
			if (j < n) begin
				res[8*j +: 8] = lit[8*(n-1-j) +: 8];
			end
		end
		return res;
	endfunction

	function automatic logic [KIND_BITS-1:0] word_kind(
		input logic [PREFIX_BITS-1:0] prefix,
		input logic [OFFSET_BITS-1:0] length
	);
		logic [KIND_BITS-1:0] res;
		res = KIND_IDENT;
		for (int unsigned i = 0; i < KW_COUNT; i++) begin
			if (length == OFFSET_BITS'(KW_LEN[i]) && prefix == kw_packed(i)) begin
				res = KIND_KW_FIRST + KIND_BITS'(i);
			end
		end
		return res;
	endfunction

endpackage

[hdl/kts_in_if.sv]
interface kts_in_if import kts_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       at_end;

	modport source(output valid, ch, at_end, input ready);
	modport sink(input valid, ch, at_end, output ready);
endinterface

[hdl/kts_out_if.sv]
interface kts_out_if import kts_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [KIND_BITS-1:0]   kind;
	logic [LINE_BITS-1:0]   tok_line;
	logic [LINE_BITS-1:0]   tok_column;
	logic [OFFSET_BITS-1:0] tok_start;
	logic [OFFSET_BITS-1:0] tok_length;
	logic                   last;

	modport source(output valid, kind, tok_line, tok_column, tok_start, tok_length, last,
		input ready);
	modport sink(input valid, kind, tok_line, tok_column, tok_start, tok_length, last,
		output ready);
endinterface

[hdl/kts_front.sv]
module kts_front import kts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	kts_in_if.sink   in,
	input  q_stat_t  stat,
	output logic     push,
	output entry_t   entry
);

	typedef enum logic [3:0] {
		MODE_IDLE = 4'b0001,
		MODE_INT  = 4'b0010,
		MODE_WORD = 4'b0100,
		MODE_STR  = 4'b1000
	} mode_t;

	mode_t                  mode_q, n_mode;
	logic [LINE_BITS-1:0]   cur_line_q, cur_col_q, st_line_q, st_col_q;
	logic [LINE_BITS-1:0]   n_cur_line, n_cur_col, n_st_line, n_st_col;
	logic [OFFSET_BITS-1:0] cur_off_q, st_off_q, run_q;
	logic [OFFSET_BITS-1:0] n_cur_off, n_st_off, n_run;
	logic [PREFIX_BITS-1:0] prefix_q, n_prefix;

	logic accept, is_end, is_space, is_digit, is_alpha, is_wordch, is_quote;
	logic has_f, has_o, adv;
	tok_t tok_f, tok_o;

	assign in.ready = !stat.full;
	assign accept   = in.valid && in.ready;

	always_comb begin
		is_end    = in.at_end || (in.ch == CHAR_NUL);
		is_space  = (in.ch == CHAR_SPACE) || (in.ch inside {[8'd9:8'd13]});
		is_digit  = in.ch inside {["0":"9"]};
		is_alpha  = in.ch inside {["A":"Z"], ["a":"z"]};
		is_wordch = is_alpha || is_digit || (in.ch == CHAR_UNDER);
		is_quote  = (in.ch == CHAR_QUOTE);
	end

	always_comb begin
		n_mode     = mode_q;
		n_cur_line = cur_line_q;
		n_cur_col  = cur_col_q;
		n_cur_off  = cur_off_q;
		n_st_line  = st_line_q;
		n_st_col   = st_col_q;
		n_st_off   = st_off_q;
		n_run      = run_q;
		n_prefix   = prefix_q;
		has_f      = 1'b0;
		has_o      = 1'b0;
		adv        = 1'b0;
		tok_f      = make_tok(KIND_IDENT, 1'b0, st_line_q, st_col_q, st_off_q, run_q);
		tok_o      = make_tok(KIND_EOF, 1'b0, cur_line_q, cur_col_q, cur_off_q, '0);

		if (is_end) begin
			// Pending token, then end of file; afterwards everything returns to reset.
			if (mode_q == MODE_STR) begin
				has_f      = 1'b1;
				tok_f.kind = KIND_UNTERM;
			end else if (mode_q == MODE_INT) begin
				has_f      = 1'b1;
				tok_f.kind = KIND_INTEGER;
			end else if (mode_q == MODE_WORD) begin
				has_f         = 1'b1;
				tok_f.is_word = 1'b1;
			end
			has_o      = 1'b1;
			n_mode     = MODE_IDLE;
			n_cur_line = LINE_BITS'(1);
			n_cur_col  = LINE_BITS'(1);
			n_cur_off  = '0;
			n_st_line  = LINE_BITS'(1);
			n_st_col   = LINE_BITS'(1);
			n_st_off   = '0;
			n_run      = '0;
			n_prefix   = '0;
		end else if (mode_q == MODE_STR) begin
			adv = 1'b1;
			if (is_quote) begin
				has_o  = 1'b1;
				tok_o  = make_tok(KIND_STRING, 1'b0, st_line_q, st_col_q, st_off_q, run_q);
				n_mode = MODE_IDLE;
			end else begin
				n_run = sat_inc_off(run_q);
			end
		end else if ((mode_q == MODE_INT && is_digit) || (mode_q == MODE_WORD && is_wordch)) begin
			adv   = 1'b1;
			n_run = sat_inc_off(run_q);
			if (mode_q == MODE_WORD) begin
				for (int unsigned j = 0; j < PREFIX_BYTES; j++) begin
					if (run_q == OFFSET_BITS'(j)) begin
						n_prefix[8*j +: 8] = in.ch;
					end
				end
			end
		end else begin
			// This byte ends any pending number or word, then starts something new.
			if (mode_q == MODE_INT) begin
				has_f      = 1'b1;
				tok_f.kind = KIND_INTEGER;
			end else if (mode_q == MODE_WORD) begin
				has_f         = 1'b1;
				tok_f.is_word = 1'b1;
			end
			n_mode = MODE_IDLE;
			adv    = 1'b1;
			if (is_quote) begin
				// Strings report their text from the byte after the quote.
				n_mode    = MODE_STR;
				n_st_line = cur_line_q;
				n_st_col  = cur_col_q;
				n_st_off  = sat_inc_off(cur_off_q);
				n_run     = '0;
				n_prefix  = '0;
			end else if (is_digit || is_alpha) begin
				n_mode    = is_digit ? MODE_INT : MODE_WORD;
				n_st_line = cur_line_q;
				n_st_col  = cur_col_q;
				n_st_off  = cur_off_q;
				n_run     = OFFSET_BITS'(1);
				n_prefix  = is_digit ? '0 : PREFIX_BITS'(in.ch);
			end else if (!is_space) begin
				has_o = 1'b1;
				tok_o = make_tok((in.ch == CHAR_COLON) ? KIND_COLON : KIND_UNEXPECTED, 1'b0,
					cur_line_q, cur_col_q, cur_off_q, OFFSET_BITS'(1));
			end
		end

		if (adv) begin
			if (in.ch == CHAR_NEWLINE) begin
				n_cur_line = sat_inc_line(cur_line_q);
				n_cur_col  = LINE_BITS'(1);
			end else begin
				n_cur_col = sat_inc_line(cur_col_q);
			end
			n_cur_off = sat_inc_off(cur_off_q);
		end
	end

	always_comb begin
		push         = accept && (has_f || has_o);
		entry.two    = has_f && has_o;
		entry.a      = has_f ? tok_f : tok_o;
		entry.prefix = prefix_q;
		entry.b      = tok_o;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			cur_line_q <= LINE_BITS'(1);
			cur_col_q  <= LINE_BITS'(1);
			cur_off_q  <= '0;
			st_line_q  <= LINE_BITS'(1);
			st_col_q   <= LINE_BITS'(1);
			st_off_q   <= '0;
			run_q      <= '0;
			prefix_q   <= '0;
		end else if (accept) begin
			mode_q     <= n_mode;
			cur_line_q <= n_cur_line;
			cur_col_q  <= n_cur_col;
			cur_off_q  <= n_cur_off;
			st_line_q  <= n_st_line;
			st_col_q   <= n_st_col;
			st_off_q   <= n_st_off;
			run_q      <= n_run;
			prefix_q   <= n_prefix;
		end
	end

endmodule

[hdl/kts_queue.sv]
module kts_queue import kts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  entry_t  wr_entry,
	input  logic    pop,
	output entry_t  head,
	output q_stat_t stat
);

	entry_t                 slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0]   count_q;

	assign stat.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/kts_back.sv]
module kts_back import kts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  entry_t    head,
	input  q_stat_t   stat,
	output logic      pop,
	kts_out_if.source out
);

	logic                   phase_q;
	logic                   out_valid_q, out_last_q;
	logic [KIND_BITS-1:0]   out_kind_q;
	logic [LINE_BITS-1:0]   out_line_q, out_col_q;
	logic [OFFSET_BITS-1:0] out_start_q, out_len_q;

	logic                 take, sel_last;
	tok_t                 sel;
	logic [KIND_BITS-1:0] sel_kind;

	assign take = !stat.empty && (!out_valid_q || out.ready);

	always_comb begin
		sel      = phase_q ? head.b : head.a;
		sel_last = phase_q || !head.two;
		sel_kind = sel.is_word ? word_kind(head.prefix, sel.length) : sel.kind;
		pop      = take && sel_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= !sel_last;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_kind_q  <= sel_kind;
			out_line_q  <= sel.line;
			out_col_q   <= sel.column;
			out_start_q <= sel.start;
			out_len_q   <= sel.length;
			out_last_q  <= sel_last;
		end
	end

	assign out.valid      = out_valid_q;
	assign out.kind       = out_kind_q;
	assign out.tok_line   = out_line_q;
	assign out.tok_column = out_col_q;
	assign out.tok_start  = out_start_q;
	assign out.tok_length = out_len_q;
	assign out.last       = out_last_q;

endmodule

[hdl/keyword_token_scanner.sv]
// Channel   Role   Request carries                                    Accepted when
// in        sink   ch, at_end                                         valid && ready
// out       source kind, tok_line, tok_column, tok_start, tok_length, valid && ready
//                  last
//
// One request is accepted per cycle while the queue is not full; the front scans
// the byte in the cycle it is accepted and files every token it causes as one
// entry in a four-entry queue. The back emits one token per cycle from the queue
// into an output register unless out.ready is low, which stalls the back alone;
// a request's tokens go out in turn, via a queue slot and then the output register.
// Reset is asynchronous and clears all scanner state and queue pointers and count
// at once, but not the queue slots. in.ready falls only while the queue is full.
module keyword_token_scanner import kts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	kts_in_if.sink    in,
	kts_out_if.source out
);

	// The front keeps position counters and the pending token, and decides per
	// byte which tokens are complete. Word kinds are resolved in the back by a
	// parallel compare against the twelve keywords.
	logic    q_push, q_pop;
	entry_t  q_wr_entry, q_head;
	q_stat_t q_stat;

	kts_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in),
		.stat   (q_stat),
		.push   (q_push),
		.entry  (q_wr_entry)
	);

	kts_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	kts_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.stat   (q_stat),
		.pop    (q_pop),
		.out    (out)
	);

	// The queue is never written while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue written while full");

	// The second token of a request follows straight after the first.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.ready && !out.last |=> out.valid)
		else $error("second token of a request did not follow");

	// End of file always closes the tokens of its request.
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.kind == KIND_EOF |-> out.last)
		else $error("end-of-file token not marked last");

	// Nothing is popped from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue read while empty");

endmodule

[tb/sv/tb_keyword_token_scanner.sv]
`timescale 1ns / 100ps

// Self-checking bench for the keyword token scanner.
// An initial block plans every source byte up front into a queue of pending
// requests. A clocked driver offers them on the input channel with random
// gaps. Every accepted request is run through a predictor of the scanner,
// which appends the tokens it should cause to a queue of tokens due.
// A clocked monitor compares every token accepted on the output channel,
// field by field, with the oldest token due.
module tb_keyword_token_scanner;
	import kts_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES    = 16;
	localparam int unsigned RANDOM_REQUESTS = 850;
	localparam int unsigned PRESSURE_AFTER  = 150;
	localparam int unsigned PRESSURE_CYCLES = 400;

	localparam logic [LINE_BITS-1:0]   LINE_TOP   = '1;
	localparam logic [OFFSET_BITS-1:0] OFFSET_TOP = '1;
	// Whitespace other than space is the contiguous range tab .. carriage return.
	localparam logic [7:0] CHAR_TAB = 8'd9;
	localparam logic [7:0] CHAR_CR  = 8'd13;
	localparam logic [7:0] CASE_BIT = 8'h20;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_INT, SCAN_WORD, SCAN_STR} scan_e;

	typedef struct packed {
		logic [KIND_BITS-1:0]   kind;
		logic [LINE_BITS-1:0]   line;
		logic [LINE_BITS-1:0]   column;
		logic [OFFSET_BITS-1:0] start;
		logic [OFFSET_BITS-1:0] length;
		logic                   last;
	} token_t;

	// A planned request; rush means no gap is left after it.
	typedef struct packed {
		logic [7:0] ch;
		logic       at_end;
		logic       rush;
	} byte_req_t;

	logic clk;
	logic arst_n;

	kts_in_if  in_ch();
	kts_out_if out_ch();

	keyword_token_scanner u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch),
		.out    (out_ch)
	);

	// Keywords in the order of their kinds, starting at the first keyword kind.
	string keyword_list [KW_COUNT] = '{
		"Process", "called", "returns", "Integer", "Return", "End",
		"Let", "be", "Set", "to", "plus", "minus"
	};

	byte_req_t bytes_pending [$];
	token_t    tokens_due [$];
	int        planned;
	int        burst_left;
	bit        rush_all;
	int        failures = 0;

	// Predictor state: where the next byte sits, and the token being built.
	scan_e                  scan_mode;
	logic [LINE_BITS-1:0]   pos_line;
	logic [LINE_BITS-1:0]   pos_column;
	logic [OFFSET_BITS-1:0] pos_offset;
	logic [LINE_BITS-1:0]   head_line;
	logic [LINE_BITS-1:0]   head_column;
	logic [OFFSET_BITS-1:0] head_offset;
	logic [OFFSET_BITS-1:0] run_len;
	// Only the first seven bytes of a word matter for the keyword match.
	string                  word_head;
	token_t                 batch [2];
	int                     batch_n;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [LINE_BITS-1:0] bump_line(input logic [LINE_BITS-1:0] v);
		return (v == LINE_TOP) ? v : v + 1'b1;
	endfunction

	function automatic logic [OFFSET_BITS-1:0] bump_offset(input logic [OFFSET_BITS-1:0] v);
		return (v == OFFSET_TOP) ? v : v + 1'b1;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
	endfunction

	function automatic bit is_digit_byte(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic void clear_scanner();
		scan_mode   = SCAN_IDLE;
		pos_line    = LINE_BITS'(1);
		pos_column  = LINE_BITS'(1);
		pos_offset  = '0;
		head_line   = LINE_BITS'(1);
		head_column = LINE_BITS'(1);
		head_offset = '0;
		run_len     = '0;
		word_head   = "";
	endfunction

	function automatic void note_token(
		input logic [KIND_BITS-1:0]   kind,
		input logic [LINE_BITS-1:0]   line,
		input logic [LINE_BITS-1:0]   column,
		input logic [OFFSET_BITS-1:0] start,
		input logic [OFFSET_BITS-1:0] length
	);
		token_t t;
		t.kind   = kind;
		t.line   = line;
		t.column = column;
		t.start  = start;
		t.length = length;
		t.last   = 1'b0;
		batch[batch_n] = t;
		batch_n++;
	endfunction

	// A newline moves to column one of the next line, anything else one column on.
	function automatic void advance_position(input logic [7:0] c);
		if (c == CHAR_NEWLINE) begin
			pos_line   = bump_line(pos_line);
			pos_column = LINE_BITS'(1);
		end else begin
			pos_column = bump_line(pos_column);
		end
		pos_offset = bump_offset(pos_offset);
	endfunction

	function automatic void open_token(input scan_e mode);
		scan_mode   = mode;
		head_line   = pos_line;
		head_column = pos_column;
		head_offset = pos_offset;
		run_len     = '0;
		word_head   = "";
	endfunction

	function automatic void extend_token(input logic [7:0] c);
		if (scan_mode == SCAN_WORD && run_len < PREFIX_BYTES) begin
			word_head = $sformatf("%s%c", word_head, c);
		end
		run_len = bump_offset(run_len);
		advance_position(c);
	endfunction

	function automatic logic [KIND_BITS-1:0] classify_word();
		for (int i = 0; i < KW_COUNT; i++) begin
			if (run_len == OFFSET_BITS'(keyword_list[i].len()) && word_head == keyword_list[i]) begin
				return KIND_KW_FIRST + KIND_BITS'(i);
			end
		end
		return KIND_IDENT;
	endfunction

	// Closes a pending integer or word; strings are closed elsewhere.
	function automatic void flush_run_token();
		if (scan_mode == SCAN_INT) begin
			note_token(KIND_INTEGER, head_line, head_column, head_offset, run_len);
			scan_mode = SCAN_IDLE;
		end else if (scan_mode == SCAN_WORD) begin
			note_token(classify_word(), head_line, head_column, head_offset, run_len);
			scan_mode = SCAN_IDLE;
		end
	endfunction

	// Works out the tokens that one accepted request causes and files them.
	function automatic void tokenise_byte(input logic [7:0] c, input logic at_end);
		token_t t;
		batch_n = 0;
		if (at_end || c == CHAR_NUL) begin
			// End of text: flush what is pending, then the end-of-file token.
			if (scan_mode == SCAN_STR) begin
				note_token(KIND_UNTERM, head_line, head_column, head_offset, run_len);
			end else begin
				flush_run_token();
			end
			note_token(KIND_EOF, pos_line, pos_column, pos_offset, '0);
			clear_scanner();
		end else if (scan_mode == SCAN_STR) begin
			if (c == CHAR_QUOTE) begin
				note_token(KIND_STRING, head_line, head_column, head_offset, run_len);
				scan_mode = SCAN_IDLE;
				advance_position(c);
			end else begin
				extend_token(c);
			end
		end else if (scan_mode == SCAN_INT && is_digit_byte(c)) begin
			extend_token(c);
		end else if (scan_mode == SCAN_WORD
				&& (is_letter(c) || is_digit_byte(c) || c == CHAR_UNDER)) begin
			extend_token(c);
		end else begin
			// This byte ends any pending run and is then scanned afresh.
			flush_run_token();
			if (is_blank(c)) begin
				advance_position(c);
			end else if (c == CHAR_QUOTE) begin
				// The string's text starts after the opening quote.
				open_token(SCAN_STR);
				advance_position(c);
				head_offset = pos_offset;
			end else if (is_digit_byte(c)) begin
				open_token(SCAN_INT);
				extend_token(c);
			end else if (is_letter(c)) begin
				open_token(SCAN_WORD);
				extend_token(c);
			end else begin
				note_token((c == CHAR_COLON) ? KIND_COLON : KIND_UNEXPECTED,
					pos_line, pos_column, pos_offset, OFFSET_BITS'(1));
				advance_position(c);
			end
		end
		for (int i = 0; i < batch_n; i++) begin
			t = batch[i];
			t.last = (i == batch_n - 1);
			tokens_due.push_back(t);
		end
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic void push_byte(input logic [7:0] c);
		byte_req_t r;
		r.ch     = c;
		r.at_end = 1'b0;
		r.rush   = rush_all || burst_left > 0;
		bytes_pending.push_back(r);
		planned++;
	endfunction

	// End of text, either by the marker with any byte beside it or by a zero byte.
	function automatic void push_end(input logic [7:0] c, input logic mark);
		byte_req_t r;
		r.ch     = mark ? c : CHAR_NUL;
		r.at_end = mark;
		r.rush   = rush_all || burst_left > 0;
		bytes_pending.push_back(r);
		planned++;
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_byte(s[i]);
		end
	endfunction

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
	endfunction

	function automatic logic [7:0] rand_word_char();
		int r;
		r = $urandom_range(0, 62);
		if (r < 52) begin
			return rand_letter();
		end else if (r < 62) begin
			return 8'("0" + r - 52);
		end
		return CHAR_UNDER;
	endfunction

	function automatic logic [7:0] rand_blank();
		int r;
		r = $urandom_range(0, 5);
		return (r == 0) ? CHAR_SPACE : 8'(CHAR_TAB + r - 1);
	endfunction

	// One random lexical element, mostly well formed, then maybe a separator.
	function automatic void plan_segment();
		int    sel;
		int    n;
		string w;
		logic [7:0] c;
		if (burst_left > 0) begin
			burst_left--;
		end else if ($urandom_range(0, 19) == 0) begin
			burst_left = $urandom_range(8, 20);
		end
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			// Keywords, and near misses that must come out as identifiers.
			w = keyword_list[$urandom_range(0, KW_COUNT - 1)];
			case ($urandom_range(0, 5))
				3: begin
					push_text(w);
					push_byte(rand_word_char());
				end
				4: begin
					push_text(w.substr(0, w.len() - 2));
				end
				5: begin
					c = w[0];
					push_byte(c ^ CASE_BIT);
					push_text(w.substr(1, w.len() - 1));
				end
				default: begin
					push_text(w);
				end
			endcase
		end else if (sel < 40) begin
			push_byte(rand_letter());
			n = $urandom_range(0, 11);
			repeat (n) push_byte(rand_word_char());
		end else if (sel < 55) begin
			n = $urandom_range(1, 7);
			repeat (n) push_byte(8'($urandom_range("0", "9")));
		end else if (sel < 65) begin
			// Strings with any content byte but zero or a quote; some are left open at end of text.
			push_byte(CHAR_QUOTE);
			n = $urandom_range(0, 8);
			repeat (n) begin
				c = 8'($urandom_range(1, 255));
				push_byte((c == CHAR_QUOTE) ? CHAR_SPACE : c);
			end
			if ($urandom_range(0, 9) != 0) begin
				push_byte(CHAR_QUOTE);
			end else begin
				push_end(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end else if (sel < 75) begin
			push_byte(CHAR_COLON);
		end else if (sel < 83) begin
			n = $urandom_range(1, 3);
			repeat (n) push_byte(rand_blank());
		end else if (sel < 95) begin
			// Noise: any byte at all, a zero byte included.
			push_byte(8'($urandom_range(0, 255)));
		end else begin
			push_end(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
		if ($urandom_range(0, 99) < 45) begin
			n = $urandom_range(1, 2);
			repeat (n) push_byte(rand_blank());
		end
	endfunction

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 2);
		end else if (r < 97) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(20, 50);
	endfunction

	// ---------------------------------------------------------------- driver

	byte_req_t next_req;
	int        gap_left;

	// Each accepted request is predicted at the edge that accepts it; the
	// next one is put up only once the current one has gone, after its gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid  <= 1'b0;
			in_ch.ch     <= '0;
			in_ch.at_end <= 1'b0;
			gap_left     <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				tokenise_byte(in_ch.ch, in_ch.at_end);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left    <= gap_left - 1;
					in_ch.valid <= 1'b0;
				end else if (bytes_pending.size() > 0) begin
					next_req      = bytes_pending.pop_front();
					in_ch.valid  <= 1'b1;
					in_ch.ch     <= next_req.ch;
					in_ch.at_end <= next_req.at_end;
					gap_left     <= next_req.rush ? 0 : gap_cycles();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	int tokens_seen = 0;
	int hold_left;
	bit pressure_done;
	int ready_roll;

	// Random stalls, with calm stretches where the output is always taken.
	// Once, well into the run, the output is held off for a long stretch so
	// that the internal queue fills and the input is pushed back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready  <= 1'b0;
			hold_left     <= 0;
			pressure_done <= 1'b0;
		end else if (!pressure_done && tokens_seen >= PRESSURE_AFTER) begin
			out_ch.ready  <= 1'b0;
			hold_left     <= PRESSURE_CYCLES;
			pressure_done <= 1'b1;
		end else if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if ((tokens_seen % 256) < 48) begin
			out_ch.ready <= 1'b1;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 75) begin
				out_ch.ready <= 1'b1;
			end else if (ready_roll < 95) begin
				out_ch.ready <= 1'b0;
				hold_left    <= $urandom_range(0, 2);
			end else begin
				out_ch.ready <= 1'b0;
				hold_left    <= $urandom_range(14, 40);
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	token_t got_tok;
	token_t due_tok;

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got_tok.kind   = out_ch.kind;
			got_tok.line   = out_ch.tok_line;
			got_tok.column = out_ch.tok_column;
			got_tok.start  = out_ch.tok_start;
			got_tok.length = out_ch.tok_length;
			got_tok.last   = out_ch.last;
			tokens_seen   <= tokens_seen + 1;
			if (tokens_due.size() == 0) begin
				$error("token with none due: kind %0d line %0d column %0d",
					got_tok.kind, got_tok.line, got_tok.column);
				failures++;
			end else begin
				due_tok = tokens_due.pop_front();
				if (got_tok.kind !== due_tok.kind) begin
					$error("kind: expected %0d, got %0d", due_tok.kind, got_tok.kind);
					failures++;
				end
				if (got_tok.line !== due_tok.line) begin
					$error("tok_line: expected %0d, got %0d", due_tok.line, got_tok.line);
					failures++;
				end
				if (got_tok.column !== due_tok.column) begin
					$error("tok_column: expected %0d, got %0d", due_tok.column, got_tok.column);
					failures++;
				end
				if (got_tok.start !== due_tok.start) begin
					$error("tok_start: expected %0d, got %0d", due_tok.start, got_tok.start);
					failures++;
				end
				if (got_tok.length !== due_tok.length) begin
					$error("tok_length: expected %0d, got %0d", due_tok.length, got_tok.length);
					failures++;
				end
				if (got_tok.last !== due_tok.last) begin
					$error("last: expected %0d, got %0d", due_tok.last, got_tok.last);
					failures++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	int quiet_cycles;

	// A run in which nothing moves on either channel for this long is hung.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- sequence

	int random_from;

	initial begin
		arst_n       = 1'b0;
		planned      = 0;
		burst_left   = 0;
		rush_all     = 1'b0;
		clear_scanner();

		// Directed: a two-letter keyword ended by a colon, an integer with both
		// extreme digits ended by a letter, a word with an underscore ended by a
		// quote, a string spanning a newline, a delete, a top-bit byte and a
		// control byte, a string cut off by a zero byte, bare whitespace before
		// the end marker, and a keyword flushed by the end marker.
		push_text("to:09aZ_\"x\n\"");
		push_byte(8'h7F);
		push_byte(8'hFF);
		push_byte(8'h01);
		push_text("\"q");
		push_end(CHAR_NUL, 1'b0);
		push_byte(CHAR_TAB);
		push_byte(CHAR_CR);
		push_end(8'hFF, 1'b1);
		push_text("End");
		push_end("x", 1'b1);

		// Offered back to back: a mixed line ended by a top-bit byte, then a
		// string holding several newlines, and a keyword cut off by a zero byte.
		rush_all = 1'b1;
		push_text("abc12345 99 :");
		push_byte(8'h80);
		push_end("Q", 1'b1);
		push_byte(CHAR_QUOTE);
		repeat (6) push_byte(CHAR_NEWLINE);
		push_byte(CHAR_QUOTE);
		push_text(" be:");
		push_byte(CHAR_NEWLINE);
		push_text("Let");
		push_end(CHAR_NUL, 1'b0);
		rush_all = 1'b0;

		random_from = planned;
		while (planned - random_from < RANDOM_REQUESTS) begin
			plan_segment();
		end
		push_end(8'($urandom_range(0, 255)), 1'b1);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_pending.size() != 0 || in_ch.valid || tokens_due.size() != 0) begin
			@(posedge clk);
		end
		// Give any stray token time to show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
